/* rtl/afc_pkg.sv */
// afc_pkg: shared types and constants for the affinity format checker
// phase and status codes, long-name text table and name lengths
// no dependencies
`default_nettype none

package afc_pkg;

	localparam int NAME_COUNT = 10;
	localparam int NAME_BYTES = 16;

	// one-hot parse phases
	typedef enum logic [6:0] {
		PH_TEXT   = 7'b0000001,
		PH_PCT    = 7'b0000010,
		PH_PAD    = 7'b0000100,
		PH_SIZE0  = 7'b0001000,
		PH_DIGITS = 7'b0010000,
		PH_LONG   = 7'b0100000,
		PH_CLOSE  = 7'b1000000
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_NO_FIELD    = 4'd1,
		ST_SIZE_ZERO   = 4'd2,
		ST_BAD_CHAR    = 4'd3,
		ST_BAD_LONG    = 4'd4,
		ST_NO_BRACE    = 4'd5,
		ST_BAD_SHORT   = 4'd6,
		ST_NO_DOT      = 4'd7,
		ST_NO_SIZE     = 4'd8,
		ST_END_EARLY   = 4'd9
	} status_t;

	typedef logic [NAME_COUNT-1:0] cand_t;

	// long names, first character in the most significant used byte
	localparam logic [8*NAME_BYTES-1:0] NAME_TEXT [NAME_COUNT] = '{
		128'h7465616d5f6e756d,
		128'h6e756d5f7465616d73,
		128'h6e657374696e675f6c6576656c,
		128'h7468726561645f6e756d,
		128'h6e756d5f74687265616473,
		128'h616e636573746f725f746e756d,
		128'h686f7374,
		128'h70726f636573735f6964,
		128'h6e61746976655f7468726561645f6964,
		128'h7468726561645f616666696e697479
	};

	localparam logic [4:0] NAME_LEN [NAME_COUNT] = '{
		5'd8, 5'd9, 5'd13, 5'd10, 5'd11, 5'd13, 5'd4, 5'd10, 5'd16, 5'd15
	};

	localparam cand_t ALL_NAMES = '1;

	// result of a type specifier byte
	typedef struct packed {
		phase_t  phase;
		logic    load_long;
		status_t err;
	} type_res_t;

endpackage

`default_nettype wire

/* rtl/affinity_format_checker.sv */
// affinity_format_checker: checks a zero-terminated format string one byte a beat
// status comes from the result register once the terminator leaves the input
// register; throughput: one byte per cycle, but the terminator waits while a
// status is unread; the input register, one pass of phase and name-match logic
// and the status register set that rate; reset (arst_n low, asynchronous): plain
// text phase, no field seen, no error; depends on afc_pkg
`default_nettype none

module affinity_format_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       ch_valid,
	output logic            ch_ready,
	input  wire logic [7:0] ch,
	output logic            status_valid,
	input  wire logic       status_ready,
	output logic [3:0]      status
);

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;

	// parse state
	afc_pkg::phase_t  phase_q;
	afc_pkg::cand_t   cand_q;
	logic [4:0]       pos_q;
	logic             seen_q;
	afc_pkg::status_t err_q;

	// result register
	logic            out_valid_q;
	afc_pkg::status_t status_q;

	// next-state values
	afc_pkg::phase_t  phase_n;
	afc_pkg::cand_t   cand_n;
	logic [4:0]       pos_n;
	logic             seen_n;
	afc_pkg::status_t err_n;
	afc_pkg::status_t result;

	logic has_result;
	logic s1_go;

	// byte classes of the staged character
	logic is_digit;
	logic is_nz_digit;
	logic is_letter;
	logic is_short;

	// long-name match
	afc_pkg::cand_t keep;
	logic [afc_pkg::NAME_COUNT-1:0] done_vec;
	afc_pkg::type_res_t tres;

	assign is_digit    = (ch_s1 >= "0") && (ch_s1 <= "9");
	assign is_nz_digit = (ch_s1 >= "1") && (ch_s1 <= "9");
	assign is_letter   = ((ch_s1 >= "a") && (ch_s1 <= "z")) ||
		((ch_s1 >= "A") && (ch_s1 <= "Z"));
	assign is_short    = (ch_s1 == "t") || (ch_s1 == "T") || (ch_s1 == "L") ||
		(ch_s1 == "n") || (ch_s1 == "N") || (ch_s1 == "a") || (ch_s1 == "H") ||
		(ch_s1 == "P") || (ch_s1 == "i") || (ch_s1 == "A");

	// type specifier: brace opens a long name, short letter ends the field, else an error
	always_comb begin
		tres.phase     = afc_pkg::PH_TEXT;
		tres.load_long = 1'b0;
		tres.err       = afc_pkg::ST_OK;
		if (ch_s1 == "{") begin
			tres.phase     = afc_pkg::PH_LONG;
			tres.load_long = 1'b1;
		end else if (is_short) begin
			tres.phase = afc_pkg::PH_TEXT;
		end else if (ch_s1 == 8'd0) begin
			tres.err = afc_pkg::ST_END_EARLY;
		end else begin
			tres.err = afc_pkg::ST_BAD_SHORT;
		end
	end

	// all ten long names compared at the current position in parallel
	always_comb begin
		logic [4:0] idx;
		logic [7:0] want;
		for (int i = 0; i < afc_pkg::NAME_COUNT; i++) begin
			idx  = afc_pkg::NAME_LEN[i] - 5'd1 - pos_q;
			want = afc_pkg::NAME_TEXT[i][{idx[3:0], 3'b000} +: 8];
			keep[i] = cand_q[i] && (pos_q < afc_pkg::NAME_LEN[i]) && (want == ch_s1);
			done_vec[i] = keep[i] && ((pos_q + 5'd1) == afc_pkg::NAME_LEN[i]);
		end
	end

	// phase transition for the staged byte
	always_comb begin
		phase_n = phase_q;
		cand_n  = cand_q;
		pos_n   = pos_q;
		seen_n  = seen_q;
		err_n   = err_q;
		if (err_q == afc_pkg::ST_OK) begin
			unique case (phase_q)
				afc_pkg::PH_PCT: begin
					if (ch_s1 == 8'd0) begin
						err_n   = afc_pkg::ST_END_EARLY;
						phase_n = afc_pkg::PH_TEXT;
					end else if (ch_s1 == "%") begin
						phase_n = afc_pkg::PH_TEXT;
					end else begin
						seen_n = 1'b1;
						if (ch_s1 == "0") begin
							phase_n = afc_pkg::PH_PAD;
						end else if (ch_s1 == ".") begin
							phase_n = afc_pkg::PH_SIZE0;
						end else if (is_nz_digit) begin
							phase_n = afc_pkg::PH_DIGITS;
						end else if ((ch_s1 == "{") || is_letter) begin
							phase_n = tres.phase;
							err_n   = tres.err;
							if (tres.load_long) begin
								cand_n = afc_pkg::ALL_NAMES;
								pos_n  = '0;
							end
						end else begin
							err_n   = afc_pkg::ST_BAD_CHAR;
							phase_n = afc_pkg::PH_TEXT;
						end
					end
				end
				afc_pkg::PH_PAD: begin
					if (ch_s1 == ".") begin
						phase_n = afc_pkg::PH_SIZE0;
					end else begin
						err_n   = afc_pkg::ST_NO_DOT;
						phase_n = afc_pkg::PH_TEXT;
					end
				end
				afc_pkg::PH_SIZE0: begin
					phase_n = afc_pkg::PH_TEXT;
					if (ch_s1 == "0") begin
						err_n = afc_pkg::ST_SIZE_ZERO;
					end else if (is_nz_digit) begin
						phase_n = afc_pkg::PH_DIGITS;
					end else begin
						err_n = afc_pkg::ST_NO_SIZE;
					end
				end
				afc_pkg::PH_DIGITS: begin
					if (!is_digit) begin
						phase_n = tres.phase;
						err_n   = tres.err;
						if (tres.load_long) begin
							cand_n = afc_pkg::ALL_NAMES;
							pos_n  = '0;
						end
					end
				end
				afc_pkg::PH_LONG: begin
					if ((pos_q == 5'd0) && (ch_s1 == 8'd0)) begin
						err_n   = afc_pkg::ST_END_EARLY;
						phase_n = afc_pkg::PH_TEXT;
					end else if (keep == '0) begin
						err_n   = afc_pkg::ST_BAD_LONG;
						phase_n = afc_pkg::PH_TEXT;
					end else begin
						cand_n = keep;
						pos_n  = pos_q + 5'd1;
						if (done_vec != '0) begin
							phase_n = afc_pkg::PH_CLOSE;
						end
					end
				end
				afc_pkg::PH_CLOSE: begin
					phase_n = afc_pkg::PH_TEXT;
					if (ch_s1 != "}") begin
						err_n = afc_pkg::ST_NO_BRACE;
					end
				end
				default: begin
					// plain text, and any code that cannot arise
					phase_n = (ch_s1 == "%") ? afc_pkg::PH_PCT : afc_pkg::PH_TEXT;
				end
			endcase
		end

		// terminator: report and start over
		if (err_n != afc_pkg::ST_OK) begin
			result = err_n;
		end else if (seen_n) begin
			result = afc_pkg::ST_OK;
		end else begin
			result = afc_pkg::ST_NO_FIELD;
		end
	end

	// only the terminator beat needs room in the result register
	assign has_result = valid_s1 && (ch_s1 == 8'd0);
	assign s1_go      = valid_s1 && (!has_result || !out_valid_q || status_ready);
	assign ch_ready   = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ch_ready) begin
			valid_s1 <= ch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid && ch_ready) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afc_pkg::PH_TEXT;
			cand_q  <= afc_pkg::ALL_NAMES;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			err_q   <= afc_pkg::ST_OK;
		end else if (s1_go) begin
			if (has_result) begin
				phase_q <= afc_pkg::PH_TEXT;
				cand_q  <= afc_pkg::ALL_NAMES;
				pos_q   <= '0;
				seen_q  <= 1'b0;
				err_q   <= afc_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				cand_q  <= cand_n;
				pos_q   <= pos_n;
				seen_q  <= seen_n;
				err_q   <= err_n;
			end
		end
	end

	// result register, doubles as the output skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && has_result) begin
			out_valid_q <= 1'b1;
		end else if (status_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result) begin
			status_q <= result;
		end
	end

	assign status_valid = out_valid_q;
	assign status       = status_q;

endmodule

`default_nettype wire
